/* rtl/pi_flow_controller_antiwindup_top_macros.svh */
// assertion helpers
`ifndef PI_FLOW_CONTROLLER_ANTIWINDUP_TOP_MACROS_SVH
`define PI_FLOW_CONTROLLER_ANTIWINDUP_TOP_MACROS_SVH
`define PFC_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define PFC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

/* rtl/pfc_pkg.sv */
package pfc_pkg;
    localparam logic [2:0] REG_KP   = 3'd0;
    localparam logic [2:0] REG_KI   = 3'd1;
    localparam logic [2:0] REG_TGT  = 3'd2;
    localparam logic [2:0] REG_BND  = 3'd3;
    localparam logic [2:0] REG_FMIN = 3'd4;
    localparam logic [2:0] REG_FMAX = 3'd5;
    localparam logic [2:0] REG_DB   = 3'd6;

    typedef struct packed {
        logic load;
        logic skip;
        logic err;
        logic mul_p;
        logic mul_i;
        logic sat;
        logic div_start;
        logic div_step;
        logic acc;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic backcalc;
        logic div_done;
    } t_sts;
endpackage

/* rtl/pfc_datapath.sv */
module pfc_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic signed [31:0]   i_temp,
    input  logic signed [31:0]   i_dt,
    input  pfc_pkg::t_cmd        i_cmd,
    output pfc_pkg::t_sts        o_sts,
    output logic signed [31:0]   o_flow
);
    logic signed [31:0] r_kp, r_tgt, r_fmin, r_fmax;
    logic [30:0] r_ki, r_bnd, r_db;
    logic signed [31:0] r_int, r_temp, r_dt, r_err, r_usat;
    logic signed [48:0] r_pterm, r_iterm;
    logic r_sat;
    logic r_neg, r_ovf;
    logic [30:0] r_rem;
    logic [30:0] r_num;
    logic [30:0] r_q;
    logic [4:0] r_cnt;
    logic signed [32:0] err_full;
    logic [32:0] err_mag;
    logic signed [31:0] err_sat;
    logic signed [63:0] prod_p, prod_i, prod_e;
    logic signed [49:0] u_raw;
    logic signed [49:0] acc_sum;
    logic signed [32:0] bnd_s;
    logic signed [48:0] diff_c;
    logic [47:0] diff_mag;
    logic [32:0] rem_try;
    logic [30:0] q_cl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= 32'sd65536; r_ki <= '0; r_tgt <= 32'sd2621440;
            r_bnd <= 31'd65536000; r_fmin <= '0; r_fmax <= 32'sd65536; r_db <= '0;
            r_int <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pfc_pkg::REG_KP:   r_kp <= i_cfg_data;
                    pfc_pkg::REG_KI:   r_ki <= i_cfg_data[30:0];
                    pfc_pkg::REG_TGT:  r_tgt <= i_cfg_data;
                    pfc_pkg::REG_BND:  r_bnd <= i_cfg_data[30:0];
                    pfc_pkg::REG_FMIN: r_fmin <= i_cfg_data;
                    pfc_pkg::REG_FMAX: r_fmax <= i_cfg_data;
                    pfc_pkg::REG_DB:   r_db <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (i_cmd.acc) begin
                if (acc_sum > 50'(bnd_s)) r_int <= {1'b0, r_bnd};
                else if (acc_sum < -50'(bnd_s)) r_int <= -{1'b0, r_bnd};
                else r_int <= acc_sum[31:0];
            end
            if (i_cmd.fin) r_int <= r_neg ? -{1'b0, q_cl} : {1'b0, q_cl};
        end
    end

    assign err_full = 33'(r_temp) - 33'(r_tgt);
    assign err_mag  = err_full[32] ? 33'(-err_full) : err_full;
    assign err_sat  = (err_mag < {2'b0, r_db}) ? 32'sd0 :
                      (err_full > 33'sd2147483647) ? 32'sh7fffffff :
                      (err_full < -33'sd2147483648) ? 32'sh80000000 : err_full[31:0];
    assign prod_p = 64'(r_kp) * 64'(r_err);
    assign prod_i = $signed({33'b0, r_ki}) * 64'(r_int);
    assign prod_e = 64'(r_err) * 64'(r_dt);
    assign u_raw  = 50'(r_pterm) + 50'(r_iterm);
    assign bnd_s  = {2'b0, r_bnd};
    assign acc_sum = 50'(r_int) + 50'(prod_e >>> 16);
    assign diff_c   = 49'(r_usat) - r_pterm;
    assign diff_mag = diff_c[48] ? 48'(-diff_c) : diff_c[47:0];
    assign rem_try = {1'b0, r_rem, r_num[30]} - {2'b0, r_ki};
    assign q_cl = (r_ovf || (r_q > r_bnd)) ? r_bnd : r_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin r_temp <= i_temp; r_dt <= i_dt; end
        if (i_cmd.skip) o_flow <= r_fmin;
        if (i_cmd.err) r_err <= err_sat;
        if (i_cmd.mul_p) r_pterm <= 49'(prod_p >>> 16);
        if (i_cmd.mul_i) r_iterm <= 49'(prod_i >>> 16);
        if (i_cmd.sat) begin
            if (u_raw < 50'(r_fmin)) begin r_usat <= r_fmin; r_sat <= 1'b1; end
            else if (u_raw > 50'(r_fmax)) begin r_usat <= r_fmax; r_sat <= 1'b1; end
            else begin r_usat <= u_raw[31:0]; r_sat <= 1'b0; end
        end
        if (i_cmd.div_start) begin
            r_neg <= diff_c[48];
            r_ovf <= (diff_mag[47:15] >= {2'b0, r_ki});
            r_rem <= diff_mag[45:15];
            r_num <= {diff_mag[14:0], 16'b0};
            o_flow <= r_usat;
            r_cnt <= '0;
            r_q <= '0;
        end
        if (i_cmd.div_step) begin
            r_num <= r_num << 1;
            r_cnt <= r_cnt + 5'd1;
            if (!rem_try[32]) begin
                r_rem <= rem_try[30:0];
                r_q <= {r_q[29:0], 1'b1};
            end else begin
                r_rem <= {r_rem[29:0], r_num[30]};
                r_q <= {r_q[29:0], 1'b0};
            end
        end
    end

    assign o_sts.skip = (r_dt <= 0);
    assign o_sts.backcalc = r_sat && (r_ki != '0);
    assign o_sts.div_done = (r_cnt == 5'd31);
endmodule

/* rtl/pfc_ctrl.sv */
`include "pi_flow_controller_antiwindup_top_macros.svh"
module pfc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_out_stall,
    output logic          o_valid,
    input  pfc_pkg::t_sts i_sts,
    output pfc_pkg::t_cmd o_cmd
);
    typedef enum logic [3:0] {S_IDLE, S_CHK, S_ERR, S_MUL, S_SAT, S_DEC,
                              S_DIV, S_FIN, S_OUT} t_state;
    t_state r_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd = '0;
        o_cmd.load = (r_state == S_IDLE) && i_valid;
        case (r_state)
            S_CHK: begin o_cmd.skip = i_sts.skip; o_cmd.err = 1'b1; end
            S_ERR: begin o_cmd.mul_p = 1'b1; o_cmd.mul_i = 1'b1; end
            S_MUL: o_cmd.sat = 1'b1;
            S_SAT: o_cmd.div_start = 1'b1;
            S_DEC: begin
                o_cmd.acc = !i_sts.backcalc;
                o_cmd.div_step = i_sts.backcalc;
            end
            S_DIV: o_cmd.div_step = !i_sts.div_done;
            S_FIN: o_cmd.fin = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) r_state <= S_CHK;
                S_CHK: begin
                    if (i_sts.skip) begin r_state <= S_OUT; o_valid <= 1'b1; end
                    else r_state <= S_ERR;
                end
                S_ERR: r_state <= S_MUL;
                S_MUL: r_state <= S_SAT;
                S_SAT: r_state <= S_DEC;
                S_DEC: begin
                    if (i_sts.backcalc) r_state <= S_DIV;
                    else begin r_state <= S_OUT; o_valid <= 1'b1; end
                end
                S_DIV: if (i_sts.div_done) r_state <= S_FIN;
                S_FIN: begin r_state <= S_OUT; o_valid <= 1'b1; end
                S_OUT: if (!i_out_stall) begin r_state <= S_IDLE; o_valid <= 1'b0; end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PFC_ASSERT_IMP(a_valid_out, i_clk, i_rst_n, o_valid, r_state == S_OUT)
    `PFC_ASSERT_IMP(a_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
    `PFC_ASSERT_NEXT(a_fin, i_clk, i_rst_n, r_state == S_FIN, o_valid)
endmodule

/* rtl/pi_flow_controller_antiwindup_top.sv */
// pi flow controller with back-calculation anti-windup, signed q16.16
// input channel: i_valid/o_stall carries observed temperature and time step
// output channel: o_valid/i_stall carries one flow command word per input word
// config: i_cfg_we/i_cfg_idx/i_cfg_data, write only while idle
// one word at a time: input is stalled from acceptance until the result is taken
// a skip step goes from check to output; a plain step runs error, multiply,
// saturate and decide; back-calculation adds the 31-step restoring divider
// a quotient of 2^31 or more is caught before the divider and clamped
// next word accepted in the cycle after the result is taken
// a stalled result holds in the output register
// reset restores register defaults and clears the integrator
module pi_flow_controller_antiwindup_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic signed [31:0] i_observed_temperature,
    input  logic signed [31:0] i_time_step,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_flow_command,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    pfc_pkg::t_cmd cmd;
    pfc_pkg::t_sts sts;

    pfc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_out_stall(i_stall), .o_valid(o_valid), .i_sts(sts), .o_cmd(cmd)
    );

    pfc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_temp(i_observed_temperature), .i_dt(i_time_step),
        .i_cmd(cmd), .o_sts(sts), .o_flow(o_flow_command)
    );
endmodule

/* tb/pi_flow_controller_antiwindup_checker.sv */
module pi_flow_controller_antiwindup_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_o_stall,
    input  logic signed [31:0] i_observed_temperature,
    input  logic signed [31:0] i_time_step,
    input  logic               i_o_valid,
    input  logic               i_stall,
    input  logic signed [31:0] i_flow_command,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    logic signed [63:0] kp, tgt, fmin, fmax, integ;
    logic [63:0] ki, bnd, db;
    logic signed [31:0] flow_queue[$];
    int fails;

    assign o_fail_count = fails;
    assign o_pending = flow_queue.size();

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fails++;
    endtask

    function automatic logic signed [63:0] sext(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    task automatic predict_flow(input logic signed [31:0] temp_in,
                                input logic signed [31:0] dt_in);
        logic signed [63:0] err, mag, p, it, u, us, diff, nb;
        logic [63:0] num, q;
        logic sat;
        if (dt_in <= 0) begin
            flow_queue.push_back(fmin[31:0]);
            return;
        end
        err = sext(temp_in) - tgt;
        mag = err < 0 ? -err : err;
        if (mag < $signed(db)) err = 0;
        if (err > 64'sd2147483647) err = 64'sd2147483647;
        if (err < -64'sd2147483648) err = -64'sd2147483648;
        p = (kp * err) >>> 16;
        it = ($signed(ki) * integ) >>> 16;
        u = p + it;
        sat = 1'b1;
        if (u < fmin) us = fmin;
        else if (u > fmax) us = fmax;
        else begin
            us = u;
            sat = 1'b0;
        end
        if (sat && ki != 0) begin
            diff = us - p;
            num = (diff < 0 ? -diff : diff) << 16;
            q = num / ki;
            if (q > bnd) q = bnd;
            integ = diff < 0 ? -$signed(q) : $signed(q);
        end else begin
            nb = integ + ((err * sext(dt_in)) >>> 16);
            if (nb > $signed(bnd)) nb = bnd;
            if (nb < -$signed(bnd)) nb = -$signed(bnd);
            integ = nb;
        end
        flow_queue.push_back(us[31:0]);
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kp = 65536; ki = 0; tgt = 2621440; bnd = 65536000;
            fmin = 0; fmax = 65536; db = 0; integ = 0;
            flow_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pfc_pkg::REG_KP:   kp = sext(i_cfg_data);
                    pfc_pkg::REG_KI:   ki = i_cfg_data[30:0];
                    pfc_pkg::REG_TGT:  tgt = sext(i_cfg_data);
                    pfc_pkg::REG_BND:  bnd = i_cfg_data[30:0];
                    pfc_pkg::REG_FMIN: fmin = sext(i_cfg_data);
                    pfc_pkg::REG_FMAX: fmax = sext(i_cfg_data);
                    pfc_pkg::REG_DB:   db = i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (i_o_valid && !i_stall) begin
                if (flow_queue.size() == 0) report_mismatch("unexpected word");
                else if (i_flow_command !== flow_queue[0]) begin
                    report_mismatch($sformatf("flow %h expected %h",
                                              i_flow_command, flow_queue[0]));
                    void'(flow_queue.pop_front());
                end else void'(flow_queue.pop_front());
            end
            if (i_valid && !i_o_stall)
                predict_flow(i_observed_temperature, i_time_step);
        end
    end
endmodule

/* tb/pi_flow_controller_antiwindup_top_test.sv */
module pi_flow_controller_antiwindup_top_test;
    logic i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 0, i_cfg_we = 0;
    logic signed [31:0] i_observed_temperature = 0, i_time_step = 0;
    logic [2:0] i_cfg_idx = 0;
    logic [31:0] i_cfg_data = 0;
    logic o_stall, o_valid;
    logic signed [31:0] o_flow_command;
    int fail_count, pending, cycles;

    localparam int LIMIT = 1500000;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    always #2 i_clk = ~i_clk;

    pi_flow_controller_antiwindup_top dut (.*);

    pi_flow_controller_antiwindup_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_o_stall(o_stall),
        .i_observed_temperature, .i_time_step, .i_o_valid(o_valid), .i_stall,
        .i_flow_command(o_flow_command), .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending));

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 70);
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
            3: return $signed($urandom_range(0, 200 << 16)) - (100 << 16);
            default: return $urandom();
        endcase
    endfunction

    always @(negedge i_clk) begin
        if ($urandom_range(0, 3) == 0) i_stall <= ($urandom_range(0, 9) < 3);
        else if (gap_len() > 30) i_stall <= 1'b1;
        else i_stall <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_word(input logic [31:0] temp, input logic [31:0] dt);
        int g;
        g = gap_len();
        repeat (g + 1) @(negedge i_clk);
        i_observed_temperature <= temp;
        i_time_step <= dt;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (70) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_config();
        write_reg(pfc_pkg::REG_KP, $urandom_range(0, 3) == 0 ? pick32() :
                  $signed($urandom_range(0, 8 << 16)) - (4 << 16));
        write_reg(pfc_pkg::REG_KI, $urandom_range(0, 4) == 0 ? 0 :
                  ($urandom_range(0, 5) == 0 ? 32'h7fff_ffff : $urandom_range(1, 4 << 16)));
        write_reg(pfc_pkg::REG_TGT, $urandom_range(0, 4) == 0 ? pick32() : (40 << 16));
        write_reg(pfc_pkg::REG_BND, $urandom_range(0, 4) == 0 ? $urandom() :
                  $urandom_range(0, 2000 << 16));
        if ($urandom_range(0, 5) == 0) begin
            write_reg(pfc_pkg::REG_FMIN, pick32());
            write_reg(pfc_pkg::REG_FMAX, pick32());
        end else begin
            write_reg(pfc_pkg::REG_FMIN, $urandom_range(0, 1 << 16));
            write_reg(pfc_pkg::REG_FMAX, $urandom_range(1 << 16, 8 << 16));
        end
        write_reg(pfc_pkg::REG_DB, $urandom_range(0, 3) == 0 ? $urandom() :
                  $urandom_range(0, 2 << 16));
        write_reg(REG_UNUSED, $urandom());
    endtask

    initial begin
        logic [31:0] t, d;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // directed: extremes, skip step, saturation both ways
        send_word(32'h7fff_ffff, 32'h0001_0000);
        send_word(32'h8000_0000, 32'h0001_0000);
        send_word(32'h0028_0000, 32'h0);
        send_word(32'h0028_0000, 32'h8000_0000);
        send_word(32'h0030_0000, 32'h7fff_ffff);
        drain();
        write_reg(pfc_pkg::REG_KI, 32'h0000_8000);
        write_reg(pfc_pkg::REG_DB, 32'h0002_0000);
        send_word(32'h0029_0000, 32'h0001_0000);
        send_word(32'h0050_0000, 32'h0001_0000);
        send_word(32'h0000_0000, 32'h0001_0000);
        send_word(32'hffff_ffff, 32'h0000_0001);
        drain();
        // inverted range, extreme gains
        write_reg(pfc_pkg::REG_FMIN, 32'h0010_0000);
        write_reg(pfc_pkg::REG_FMAX, 32'hfff0_0000);
        write_reg(pfc_pkg::REG_KP, 32'h8000_0000);
        write_reg(pfc_pkg::REG_KI, 32'h7fff_ffff);
        write_reg(pfc_pkg::REG_BND, 32'h7fff_ffff);
        write_reg(pfc_pkg::REG_TGT, 32'h8000_0000);
        send_word(32'h7fff_ffff, 32'h7fff_ffff);
        send_word(32'h8000_0000, 32'h0001_0000);
        send_word(32'h0020_0000, 32'h0000_0001);
        drain();
        for (int i = 0; i < 1750; i++) begin
            if (i % 150 == 0) begin
                drain();
                random_config();
            end
            t = $urandom_range(0, 3) == 0 ? pick32() :
                $signed($urandom_range(0, 40 << 16)) + (20 << 16);
            d = $urandom_range(0, 7) == 0 ? pick32() : $urandom_range(1, 1 << 17);
            send_word(t, d);
        end
        drain();
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl
rtl/pfc_pkg.sv
rtl/pfc_datapath.sv
rtl/pfc_ctrl.sv
rtl/pi_flow_controller_antiwindup_top.sv
tb/pi_flow_controller_antiwindup_checker.sv
tb/pi_flow_controller_antiwindup_top_test.sv
